// ===== sv/ads_pkg.sv =====
// Shared constants, widths and types of the area-downscale ditherer.
package ads_pkg;

  localparam int SOURCE_WIDTH_DEF   = 320;
  localparam int SOURCE_HEIGHT_DEF  = 200;
  localparam int DEST_MAX_WIDTH_DEF = 128;
  localparam int DEST_HEIGHT_DEF    = 64;

  localparam int SUM_W  = 12;
  localparam int CNT_W  = 5;
  localparam int ERR_W  = 11;
  localparam int LUMA_W = 8;
  localparam int CFG_W  = 8;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CFG_W-1:0] DEST_WIDTH_RST = 8'd102;

  localparam logic [7:0] LUMA_R_COEF = 8'd77;
  localparam logic [7:0] LUMA_G_COEF = 8'd150;
  localparam logic [7:0] LUMA_B_COEF = 8'd29;

  // divider request: start pulse with operands
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== sv/ads_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ads_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/ads_div.sv =====
// Restoring divider, one quotient bit per cycle, for band averages.
module ads_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ads_pkg::div_req_t       req,
  output logic                    done,
  output logic [ads_pkg::SUM_W-1:0] quotient
);

  localparam int SW = ads_pkg::SUM_W;
  localparam int CW = ads_pkg::CNT_W;
  localparam int KW = $clog2(SW + 1);

  logic [SW-1:0] q_r, q_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] dvs_r, dvs_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [CW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[SW-1]};
    if (req.start) begin
      q_nxt   = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = KW'(SW);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = CW'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[SW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CW-1:0];
        q_nxt   = {q_r[SW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == KW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

  // a fresh request only arrives while idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> cnt_r == '0) else $error("divider restarted while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("divider done held");

endmodule

// ===== sv/area_downscale_fs_dither.sv =====
// Top level: palette lookup, area downscale and 1-bit Floyd-Steinberg dither.
//
// Input channel (in_valid / in_stall): one word is either a palette write
// (in_operation = 0: color_index is the address, red/green/blue the entry)
// or a source pixel in raster order (in_operation = 1), with in_frame_start
// marking the first pixel of a frame. The block stalls the input while it
// works on a word.
// Result channel (out_valid / out_stall): one dithered pixel per finished
// band, with its destination column and row and a frame_done flag on the
// last pixel of the frame. The result sits in an output register; a held
// stall on the result side stops the block only when the next result is due.
// Config: cfg_write_en / cfg_write_data set dest_width; the user writes it only while idle (not enforced).
// Per word: a palette write is taken in idle without a stall; a source pixel passes the
// band search (column and row step together), accumulation and advance states; a pixel
// that closes a band also waits on the divider for the band average and then does the
// error updates. The divider and the column memory, with one read and one write port,
// set the time per word.
// Reset (synchronous, rst_n low): position, errors and band sums clear,
// dest_width returns to 102; palette contents are undefined until written.
module area_downscale_fs_dither #(
  parameter int SOURCE_WIDTH   = ads_pkg::SOURCE_WIDTH_DEF,
  parameter int SOURCE_HEIGHT  = ads_pkg::SOURCE_HEIGHT_DEF,
  parameter int DEST_MAX_WIDTH = ads_pkg::DEST_MAX_WIDTH_DEF,
  parameter int DEST_HEIGHT    = ads_pkg::DEST_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  logic [ads_pkg::CFG_W-1:0]      cfg_write_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic                           in_frame_start,
  input  logic [7:0]                     in_color_index,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [$clog2(DEST_MAX_WIDTH)-1:0] out_dest_x,
  output logic [$clog2(DEST_HEIGHT)-1:0]    out_dest_y,
  output logic                           out_white,
  output logic                           out_frame_done
);

  localparam int SUM_W = ads_pkg::SUM_W;
  localparam int CNT_W = ads_pkg::CNT_W;
  localparam int ERR_W = ads_pkg::ERR_W;
  localparam int DXW   = $clog2(DEST_MAX_WIDTH);
  localparam int DYW   = $clog2(DEST_HEIGHT);
  localparam int WW    = $clog2(DEST_MAX_WIDTH + 1);
  localparam int SXW   = $clog2(SOURCE_WIDTH);
  localparam int SYW   = $clog2(SOURCE_HEIGHT);
  localparam int XPW   = $clog2((SOURCE_WIDTH + 2) * (DEST_MAX_WIDTH + 2) + 1);
  localparam int YPW   = $clog2((SOURCE_HEIGHT + 2) * (DEST_HEIGHT + 2) + 1);
  localparam int ENT_W = SUM_W + CNT_W + ERR_W;
  localparam int VW    = ERR_W + 2;
  localparam int MW    = VW + 3;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WALK = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_FIN  = 4'd4;
  localparam logic [3:0] S_RDL  = 4'd5;
  localparam logic [3:0] S_WRL  = 4'd6;
  localparam logic [3:0] S_ADV  = 4'd7;

  // truncate toward zero after dividing by 16
  function automatic logic signed [ERR_W-1:0] share16(input logic signed [MW-1:0] x);
    logic signed [MW-1:0] t;
    t = x + (x[MW-1] ? MW'(15) : MW'(0));
    return t[ERR_W+3:4];
  endfunction

  logic [3:0]       state_r, state_nxt;
  logic [ads_pkg::CFG_W-1:0] dest_width_r, dest_width_nxt;
  logic [SXW-1:0]   sx_r, sx_nxt;
  logic [SYW-1:0]   sy_r, sy_nxt;
  logic [DXW-1:0]   dx_r, dx_nxt;
  logic [DYW-1:0]   dy_r, dy_nxt;
  logic signed [ERR_W-1:0] right_r, right_nxt;
  logic signed [ERR_W-1:0] diag_r, diag_nxt;
  logic signed [ERR_W-1:0] below_r, below_nxt;
  logic signed [ERR_W-1:0] sh3_r, sh3_nxt;
  logic [DEST_MAX_WIDTH-1:0] vld_r, vld_nxt;
  logic             emit_y_r, emit_y_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DXW-1:0]   out_x_r, out_x_nxt;
  logic [DYW-1:0]   out_y_r, out_y_nxt;
  logic             out_white_r, out_white_nxt;
  logic             out_done_r, out_done_nxt;

  logic [WW-1:0]    w_act;
  logic             accept;
  logic [15:0]      luma_sum;
  logic [7:0]       pal_rd;
  logic             col_re, col_we;
  logic [DXW-1:0]   col_raddr, col_waddr;
  logic [ENT_W-1:0] col_rd, col_wd, entry;
  logic [XPW-1:0]   px, ax;
  logic [YPW-1:0]   py, ay;
  logic             adv_x, adv_y, emit_x, emit_yc;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] cnt_new;
  ads_pkg::div_req_t div_req;
  logic             div_done;
  logic [SUM_W-1:0] div_q;
  logic [7:0]       avg;
  logic signed [VW-1:0] value, err;
  logic signed [MW-1:0] e16, m7, m5, m3;
  logic             white, last_col, last_row, fin_go;

  always_comb begin
    w_act = WW'(dest_width_r);
    if (dest_width_r == '0) w_act = WW'(1);
    if (WW'(dest_width_r) > WW'(DEST_MAX_WIDTH)) w_act = WW'(DEST_MAX_WIDTH);
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign luma_sum = 16'(ads_pkg::LUMA_R_COEF * in_red) + 16'(ads_pkg::LUMA_G_COEF * in_green)
                  + 16'(ads_pkg::LUMA_B_COEF * in_blue);

  ads_ram #(.WIDTH(8), .DEPTH(256)) u_pal (
    .clk, .wr_en(accept && !in_operation), .wr_addr(in_color_index),
    .wr_data(luma_sum[15:8]), .rd_en(accept && in_operation),
    .rd_addr(in_color_index), .rd_data(pal_rd)
  );

  ads_ram #(.WIDTH(ENT_W), .DEPTH(DEST_MAX_WIDTH)) u_col (
    .clk, .wr_en(col_we), .wr_addr(col_waddr), .wr_data(col_wd),
    .rd_en(col_re), .rd_addr(col_raddr), .rd_data(col_rd)
  );

  ads_div u_div (.clk, .rst_n, .req(div_req), .done(div_done), .quotient(div_q));

  // band bounds as cross-multiplied compares: end(d) <= s  <=>  (d+1)*N < (s+1)*w
  assign px = XPW'((XPW'(sx_r) + XPW'(1)) * XPW'(w_act));
  assign ax = XPW'((XPW'(dx_r) + XPW'(1)) * XPW'(SOURCE_WIDTH));
  assign py = YPW'((YPW'(sy_r) + YPW'(1)) * YPW'(DEST_HEIGHT));
  assign ay = YPW'((YPW'(dy_r) + YPW'(1)) * YPW'(SOURCE_HEIGHT));
  assign adv_x   = (WW'(dx_r) + WW'(1) < w_act) && (ax < px);
  assign adv_y   = (32'(dy_r) + 1 < DEST_HEIGHT) && (ay < py);
  assign emit_x  = (px <= ax) && (ax < px + XPW'(w_act));
  assign emit_yc = (py <= ay) && (ay < py + YPW'(DEST_HEIGHT));

  // left neighbor is addressed while it is read and while it is written back
  assign col_raddr = (state_r == S_RDL || state_r == S_WRL) ? dx_r - 1'b1 : dx_r;
  assign entry     = vld_r[col_raddr] ? col_rd : '0;
  assign sum_add   = {1'b0, entry[ENT_W-1 -: SUM_W]} + (SUM_W+1)'(pal_rd);
  assign sum_new   = sum_add[SUM_W] ? ads_pkg::SUM_MAX : sum_add[SUM_W-1:0];
  assign cnt_new   = (entry[ERR_W +: CNT_W] == ads_pkg::CNT_MAX) ? ads_pkg::CNT_MAX
                   : entry[ERR_W +: CNT_W] + 1'b1;

  assign avg      = (div_q > SUM_W'(255)) ? 8'd255 : div_q[7:0];
  assign value    = $signed(VW'(avg)) + VW'(right_r) + VW'(below_r);
  assign white    = value >= $signed(VW'(128));
  assign err      = white ? value - $signed(VW'(255)) : value;
  assign e16      = MW'(err);
  assign m7       = (e16 <<< 3) - e16;
  assign m5       = (e16 <<< 2) + e16;
  assign m3       = (e16 <<< 1) + e16;
  assign last_col = (WW'(dx_r) + WW'(1) >= w_act);
  assign last_row = (32'(dy_r) + 1 >= DEST_HEIGHT);
  assign fin_go   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    dest_width_nxt = cfg_write_en ? cfg_write_data : dest_width_r;
    sx_nxt = sx_r;  sy_nxt = sy_r;  dx_nxt = dx_r;  dy_nxt = dy_r;
    right_nxt = right_r;  diag_nxt = diag_r;  below_nxt = below_r;  sh3_nxt = sh3_r;
    vld_nxt = vld_r;  emit_y_nxt = emit_y_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt = out_x_r;  out_y_nxt = out_y_r;
    out_white_nxt = out_white_r;  out_done_nxt = out_done_r;
    col_re = 1'b0;  col_we = 1'b0;  col_waddr = dx_r;  col_wd = '0;
    div_req = '{start: 1'b0, dividend: sum_new, divisor: cnt_new};

    case (state_r)
      S_IDLE: begin
        if (accept && in_operation) begin
          if (in_frame_start) begin
            sx_nxt = '0;  sy_nxt = '0;  dx_nxt = '0;  dy_nxt = '0;
            right_nxt = '0;  diag_nxt = '0;  vld_nxt = '0;
          end else if (WW'(dx_r) >= w_act) begin
            dx_nxt = DXW'(w_act - WW'(1));
          end
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (adv_x) dx_nxt = dx_r + 1'b1;
        if (adv_y) dy_nxt = dy_r + 1'b1;
        if (!adv_x && !adv_y) begin
          col_re     = 1'b1;
          emit_y_nxt = emit_yc;
          state_nxt  = S_ACC;
        end
      end
      S_ACC: begin
        below_nxt = entry[ERR_W-1:0];
        if (emit_x && emit_y_r) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          col_we         = 1'b1;
          col_wd         = {sum_new, cnt_new, entry[ERR_W-1:0]};
          vld_nxt[dx_r]  = 1'b1;
          state_nxt      = S_ADV;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = dx_r;
          out_y_nxt     = dy_r;
          out_white_nxt = white;
          out_done_nxt  = last_col && last_row;
          right_nxt     = last_col ? '0 : share16(m7);
          sh3_nxt       = share16(m3);
          col_we        = 1'b1;
          vld_nxt[dx_r] = 1'b1;
          if (last_row) begin
            col_wd   = '0;
            diag_nxt = '0;
          end else begin
            col_wd   = {{(SUM_W+CNT_W){1'b0}}, ERR_W'(diag_r + share16(m5))};
            diag_nxt = last_col ? '0 : share16(e16);
          end
          state_nxt = (!last_row && dx_r != '0) ? S_RDL : S_ADV;
        end
      end
      S_RDL: begin
        col_re    = 1'b1;
        state_nxt = S_WRL;
      end
      S_WRL: begin
        col_we    = 1'b1;
        col_waddr = dx_r - 1'b1;
        col_wd    = {entry[ENT_W-1:ERR_W], ERR_W'(entry[ERR_W-1:0] + sh3_r)};
        vld_nxt[dx_r - 1'b1] = 1'b1;
        state_nxt = S_ADV;
      end
      S_ADV: begin
        if (32'(sx_r) + 1 >= SOURCE_WIDTH) begin
          // wrap to next source row; drop the row-local errors
          sx_nxt = '0;  dx_nxt = '0;  right_nxt = '0;  diag_nxt = '0;
          if (32'(sy_r) + 1 >= SOURCE_HEIGHT) begin
            sy_nxt = '0;  dy_nxt = '0;  vld_nxt = '0;
          end else begin
            sy_nxt = sy_r + 1'b1;
          end
        end else begin
          sx_nxt = sx_r + 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dest_width_r <= ads_pkg::DEST_WIDTH_RST;
      sx_r <= '0;  sy_r <= '0;  dx_r <= '0;  dy_r <= '0;
      right_r <= '0;  diag_r <= '0;  vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dest_width_r <= dest_width_nxt;
      sx_r <= sx_nxt;  sy_r <= sy_nxt;  dx_r <= dx_nxt;  dy_r <= dy_nxt;
      right_r <= right_nxt;  diag_r <= diag_nxt;  vld_r <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    below_r     <= below_nxt;
    sh3_r       <= sh3_nxt;
    emit_y_r    <= emit_y_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_white_r <= out_white_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_dest_x     = out_x_r;
  assign out_dest_y     = out_y_r;
  assign out_white      = out_white_r;
  assign out_frame_done = out_done_r;

  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_FIN)) else $error("result from wrong state");
  a_dx_in_width: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |-> WW'(dx_r) < w_act) else $error("band column out of width");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> div_req.divisor != '0) else $error("average over empty band");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("pending result lost");

endmodule
